// ===== rtl/core/roslab_pkg.sv =====
// Shared types, constants and helpers for the ray versus oriented-box slab test.
package roslab_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FIELD_W = 32;
  localparam int VAL_W = 64;
  localparam int MAG_W = 63;
  localparam int QCAP_EXP = 40;
  localparam int DIG_W = 16;
  localparam int THR_W = 17;
  localparam int DIST_W = 33;
  localparam int CFG_IDX_W = 1;

  localparam logic signed [VAL_W-1:0] VAL_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 1'd1;

  typedef struct packed {
    logic [2:0]                mode;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic signed [FIELD_W-1:0] coord_z;
    logic                      evaluate;
  } item_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } result_t;

  function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s > (VAL_W+1)'(VAL_LIM)) begin
      return VAL_LIM;
    end else if (s < -((VAL_W+1)'(VAL_LIM))) begin
      return -VAL_LIM;
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

// ===== rtl/core/roslab_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module roslab_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/roslab_mul.sv =====
// Digit-serial signed fixed-point multiplier with truncation and saturation.
module roslab_mul import roslab_pkg::*; #(
  parameter int OPW = COORD_WIDTH_DEF + 1,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [OPW-1:0]   a,
  input  logic signed [OPW-1:0]   b,
  output logic                    done,
  output logic signed [VAL_W-1:0] p
);

  localparam int NDIG = (OPW + DIG_W - 1) / DIG_W;
  localparam int BW = NDIG * DIG_W;
  localparam int PW = OPW + BW;
  localparam int CMPW = (PW > VAL_W) ? PW : VAL_W;
  localparam int CNTW = $clog2(NDIG + 1);

  logic                    busy;
  logic                    fin;
  logic [CNTW-1:0]         cnt;
  logic [OPW-1:0]          amag;
  logic [BW-1:0]           bsh;
  logic [PW-1:0]           acc;
  logic                    neg;
  logic [OPW+DIG_W-1:0]    prod;
  logic [PW-1:0]           rs;
  logic                    sat;
  logic signed [VAL_W-1:0] m;

  always_comb begin
    prod = amag * bsh[BW-1 -: DIG_W];
    rs = acc >> FRAC_BITS;
    sat = CMPW'(rs) > CMPW'($unsigned(VAL_LIM));
    m = sat ? VAL_LIM : $signed(VAL_W'(rs));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy && !fin) begin
        busy <= 1'b1;
        cnt <= '0;
        acc <= '0;
        amag <= a[OPW-1] ? OPW'(-a) : OPW'(a);
        bsh <= BW'(b[OPW-1] ? OPW'(-b) : OPW'(b));
        neg <= a[OPW-1] ^ b[OPW-1];
      end else if (busy) begin
        acc <= (acc << DIG_W) + PW'(prod);
        bsh <= bsh << DIG_W;
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NDIG - 1)) begin
          busy <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin <= 1'b0;
        done <= 1'b1;
        p <= neg ? -m : m;
      end
    end
  end

endmodule

// ===== rtl/core/roslab_div.sv =====
// Bit-serial restoring divider for signed fixed-point quotients with a magnitude cap.
module roslab_div import roslab_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] n,
  input  logic signed [VAL_W-1:0] d,
  output logic                    done,
  output logic signed [VAL_W-1:0] q
);

  localparam int SH = QCAP_EXP - FRAC_BITS;
  localparam int NW = MAG_W + FRAC_BITS;
  localparam int CNTW = $clog2(QCAP_EXP + 1);

  logic [MAG_W-1:0]    un;
  logic [MAG_W-1:0]    ud;
  logic [NW-1:0]       nfull;
  logic                ovf;
  logic                busy;
  logic [CNTW-1:0]     cnt;
  logic [VAL_W-1:0]    r;
  logic [MAG_W-1:0]    dv;
  logic [QCAP_EXP-1:0] nsh;
  logic [QCAP_EXP-1:0] qb;
  logic                neg;
  logic [VAL_W-1:0]    rt;
  logic                ge;
  logic [QCAP_EXP-1:0] qb_next;
  logic [VAL_W-1:0]    mag;

  always_comb begin
    un = n[VAL_W-1] ? MAG_W'(-n) : MAG_W'(n);
    ud = d[VAL_W-1] ? MAG_W'(-d) : MAG_W'(d);
    nfull = {un, {FRAC_BITS{1'b0}}};
    ovf = {{SH{1'b0}}, un} >= {ud, {SH{1'b0}}};
    rt = {r[VAL_W-2:0], nsh[QCAP_EXP-1]};
    ge = rt >= VAL_W'(dv);
    qb_next = {qb[QCAP_EXP-2:0], ge};
    mag = VAL_W'(qb_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        neg <= n[VAL_W-1] ^ d[VAL_W-1];
        if (ovf) begin
          done <= 1'b1;
          q <= (n[VAL_W-1] ^ d[VAL_W-1]) ? -(VAL_W'(1) << QCAP_EXP)
                                          : (VAL_W'(1) << QCAP_EXP);
        end else begin
          busy <= 1'b1;
          cnt <= '0;
          r <= VAL_W'(nfull[NW-1:QCAP_EXP]);
          nsh <= nfull[QCAP_EXP-1:0];
          dv <= ud;
          qb <= '0;
        end
      end else if (busy) begin
        r <= ge ? rt - VAL_W'(dv) : rt;
        nsh <= nsh << 1;
        qb <= qb_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(QCAP_EXP - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          q <= neg ? -$signed(mag) : $signed(mag);
        end
      end
    end
  end

endmodule

// ===== rtl/core/ray_obb_slab_intersect.sv =====
// Top level of the ray versus oriented-box slab intersection test.
//
//  Channel   Signals                              Moves
//  item      item_valid, item_ready, item         one 3-vector load, optional evaluate
//  result    result_valid, result_ready, result   hit flag and near distance
//  config    cfg_write_en, cfg_index, cfg_data    register write, no wait
//
// A load item is written into the store while the block is idle. The run of an
// evaluate item is dominated by the bit-serial divider (40 quotient bits per division,
// two per axis). Early rejects and parallel axes finish sooner. No clearing pass
// follows reset. A pending result stalls the next result, not the loads before it;
// while that next result waits, no loads are taken.
module ray_obb_slab_intersect import roslab_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int OPW = CW + 1;
  localparam int ROW_W = 3 * CW;

  localparam logic [2:0] SLOT_ORG = 3'd0;
  localparam logic [2:0] SLOT_DIR = 3'd1;
  localparam logic [2:0] SLOT_MAX = 3'd2;
  localparam logic [2:0] SLOT_MIN = 3'd3;
  localparam logic [2:0] SLOT_AX0 = 3'd4;
  localparam logic [2:0] SLOT_POS = 3'd7;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_LOAD   = 10'b00_0000_0010,
    S_CHECK  = 10'b00_0000_0100,
    S_AXRD   = 10'b00_0000_1000,
    S_AXCAP  = 10'b00_0001_0000,
    S_MUL    = 10'b00_0010_0000,
    S_AXEVAL = 10'b00_0100_0000,
    S_DIV1   = 10'b00_1000_0000,
    S_DIV2   = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t state;

  logic [THR_W-1:0]  thr;
  logic [DIST_W-1:0] maxd;

  logic signed [CW-1:0] org  [3];
  logic signed [CW-1:0] dir  [3];
  logic signed [CW-1:0] bmx  [3];
  logic signed [CW-1:0] bmn  [3];
  logic signed [CW-1:0] pos  [3];
  logic signed [CW-1:0] axis [3];
  logic signed [CW:0]   dlt  [3];
  logic signed [CW-1:0] row  [3];

  logic signed [VAL_W-1:0] e;
  logic signed [VAL_W-1:0] f;
  logic signed [VAL_W-1:0] tmin;
  logic signed [VAL_W-1:0] tmax;
  logic signed [VAL_W-1:0] t1;
  logic [1:0]              k;
  logic [2:0]              idx;
  logic [2:0]              ld_cnt;
  logic                    mul_run;
  logic                    res_hit;
  logic [DIST_W-1:0]       res_dist;

  logic                    wr_en;
  logic [ROW_W-1:0]        wdata;
  logic [2:0]              raddr;
  logic [ROW_W-1:0]        rdata;

  logic                    mul_start;
  logic signed [OPW-1:0]   mul_a;
  logic signed [OPW-1:0]   mul_b;
  logic                    mul_done;
  logic signed [VAL_W-1:0] mul_p;
  logic [1:0]              j;

  logic                    div_start;
  logic signed [VAL_W-1:0] div_n;
  logic                    div_done;
  logic signed [VAL_W-1:0] div_q;

  logic signed [VAL_W-1:0] absf;
  logic signed [VAL_W-1:0] lo;
  logic signed [VAL_W-1:0] hi;
  logic signed [VAL_W-1:0] ntmax;
  logic signed [VAL_W-1:0] ntmin;
  logic                    inverted;
  logic                    par_miss;

  function automatic logic [2:0] ld_slot(input logic [2:0] c);
    case (c)
      3'd0: ld_slot = SLOT_ORG;
      3'd1: ld_slot = SLOT_DIR;
      3'd2: ld_slot = SLOT_MAX;
      3'd3: ld_slot = SLOT_MIN;
      default: ld_slot = SLOT_POS;
    endcase
  endfunction

  assign item_ready = (state == S_IDLE);
  assign wr_en = item_valid && item_ready;
  assign wdata = {CW'(item.coord_z), CW'(item.coord_y), CW'(item.coord_x)};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row[i] = rdata[i*CW +: CW];
    end
    raddr = (state == S_AXRD) ? 3'(SLOT_AX0 + {1'b0, k}) : ld_slot(ld_cnt);
    j = (idx < 3'd3) ? idx[1:0] : 2'(idx - 3'd3);
    if (idx < 3'd3) begin
      mul_a = OPW'(axis[j]);
      mul_b = dlt[j];
    end else begin
      mul_a = OPW'(dir[j]);
      mul_b = OPW'(axis[j]);
    end
    mul_start = (state == S_MUL) && !mul_run;
    div_start = (state == S_AXEVAL && absf > $signed(VAL_W'(thr))) ||
                (state == S_DIV1 && div_done);
    div_n = (state == S_AXEVAL) ? sat_add(e, VAL_W'(bmn[k])) : sat_add(e, VAL_W'(bmx[k]));
    absf = f[VAL_W-1] ? -f : f;
    lo = (t1 > div_q) ? div_q : t1;
    hi = (t1 > div_q) ? t1 : div_q;
    ntmax = (hi < tmax) ? hi : tmax;
    ntmin = (lo > tmin) ? lo : tmin;
    inverted = (bmx[0] < bmn[0]) && (bmx[1] < bmn[1]) && (bmx[2] < bmn[2]);
    par_miss = (sat_add(-e, VAL_W'(bmn[k])) > 0) || (sat_add(-e, VAL_W'(bmx[k])) < 0);
  end

  roslab_ram #(.WIDTH(ROW_W), .DEPTH(8)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (item.mode),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  roslab_mul #(.OPW(OPW), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  roslab_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (div_n),
    .d     (f),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_W'(66);
      maxd <= DIST_W'(64'd6553600000);
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_PARALLEL_THRESHOLD: thr <= cfg_data[THR_W-1:0];
        CFG_MAX_DISTANCE: maxd <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      mul_run <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (wr_en && item.evaluate) begin
            ld_cnt <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          ld_cnt <= ld_cnt + 1'b1;
          if (ld_cnt != 3'd0) begin
            case (ld_slot(3'(ld_cnt - 1'b1)))
              SLOT_ORG: org <= row;
              SLOT_DIR: dir <= row;
              SLOT_MAX: bmx <= row;
              SLOT_MIN: bmn <= row;
              default: pos <= row;
            endcase
          end
          if (ld_cnt == 3'd5) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          for (int i = 0; i < 3; i++) begin
            dlt[i] <= OPW'(pos[i]) - OPW'(org[i]);
          end
          tmin <= '0;
          tmax <= $signed(VAL_W'(maxd));
          k <= '0;
          if (inverted) begin
            res_hit <= 1'b0;
            res_dist <= '0;
            state <= S_DONE;
          end else begin
            state <= S_AXRD;
          end
        end
        S_AXRD: state <= S_AXCAP;
        S_AXCAP: begin
          axis <= row;
          e <= '0;
          f <= '0;
          idx <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_start) begin
            mul_run <= 1'b1;
          end
          if (mul_done) begin
            mul_run <= 1'b0;
            if (idx < 3'd3) begin
              e <= sat_add(e, mul_p);
            end else begin
              f <= sat_add(f, mul_p);
            end
            idx <= idx + 1'b1;
            if (idx == 3'd5) begin
              state <= S_AXEVAL;
            end
          end
        end
        S_AXEVAL: begin
          if (div_start) begin
            state <= S_DIV1;
          end else if (par_miss) begin
            res_hit <= 1'b0;
            res_dist <= '0;
            state <= S_DONE;
          end else if (k == 2'd2) begin
            res_hit <= 1'b1;
            res_dist <= tmin[DIST_W-1:0];
            state <= S_DONE;
          end else begin
            k <= k + 1'b1;
            state <= S_AXRD;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            t1 <= div_q;
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            tmax <= ntmax;
            tmin <= ntmin;
            if (ntmax < ntmin) begin
              res_hit <= 1'b0;
              res_dist <= '0;
              state <= S_DONE;
            end else if (k == 2'd2) begin
              res_hit <= 1'b1;
              res_dist <= ntmin[DIST_W-1:0];
              state <= S_DONE;
            end else begin
              k <= k + 1'b1;
              state <= S_AXRD;
            end
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result <= {res_hit, res_dist};
            result_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
